// ===== rtl/csw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Counting semaphore package
// Shared widths, codes, cell types and saturating arithmetic.
// ---------------------------------------------------------------------------
package csw_pkg;

    localparam int DEF_THREAD_SLOTS = 16;
    localparam int THR_W = 4;
    localparam int REM_W = 16;
    localparam int VAL_W = 16;
    localparam int CNT_W = 8;

    localparam logic [1:0] ACT_WAIT   = 2'd0;
    localparam logic [1:0] ACT_SIGNAL = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    localparam logic [2:0] K_ACQ   = 3'd0;
    localparam logic [2:0] K_BLOCK = 3'd1;
    localparam logic [2:0] K_REL   = 3'd2;
    localparam logic [2:0] K_SIG   = 3'd3;
    localparam logic [2:0] K_TICK  = 3'd4;
    localparam logic [2:0] K_REJ   = 3'd5;

    typedef struct packed {
        logic             clear;
        logic             dec;
        logic             rm;
        logic             rm_exp_only;
        logic             push;
        logic [THR_W-1:0] thread;
        logic [REM_W-1:0] rem;
    } csw_ctl_t;

    typedef struct packed {
        logic             valid;
        logic             exp;
        logic [THR_W-1:0] thread;
        logic [REM_W-1:0] rem;
    } csw_cell_t;

    // Adds a small signed amount to the value, saturating at the 16-bit range.
    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] v,
        input logic signed [CNT_W:0]   d
    );
        logic signed [VAL_W:0] s;
        s = {v[VAL_W-1], v} + {{(VAL_W-CNT_W){d[CNT_W]}}, d};
        if (s[VAL_W] != s[VAL_W-1])
        begin
            sat_add = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        else
        begin
            sat_add = s[VAL_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/counting_semaphore_timed_waits.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Counting semaphore with timed waits
// Items enter on in_valid/in_stall and results leave on out_valid/out_stall.
// A wait gives one result: acquired, blocked or rejected. A signal with a
// negative count is rejected; otherwise it releases up to its count of waiters,
// untimed ones first, one released result per cycle while out_stall lets the
// output register load, then a signal-done result carrying the number released.
// A tick counts every timed waiter down when it is taken, then releases each
// expired waiter in list order, one per cycle under the same condition, then
// gives tick done. A signal or tick thus takes the item, passes each released
// waiter through the output register and ends with the closing result.
// The next item is taken once the last result is registered.
// Reset loads zero and a cfg_we write loads cfg_data with negative values
// clamped to zero; both empty both waiter chains. While out_stall is high with
// a result held, the output register keeps it and the sequencer waits.
// ---------------------------------------------------------------------------
module counting_semaphore_timed_waits #(
    parameter int THREAD_SLOTS = csw_pkg::DEF_THREAD_SLOTS
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_we,
    input  wire signed [csw_pkg::VAL_W-1:0] cfg_data,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire [1:0]                  action,
    input  wire [csw_pkg::THR_W-1:0]   thread_id,
    input  wire [csw_pkg::REM_W-1:0]   timeout,
    input  wire signed [csw_pkg::CNT_W-1:0] release_count,
    output logic                       out_valid,
    input  wire                        out_stall,
    output logic [2:0]                 kind,
    output logic [csw_pkg::THR_W-1:0]  released_thread,
    output logic                       timed_out,
    output logic signed [csw_pkg::CNT_W-1:0] return_value,
    output logic signed [csw_pkg::VAL_W-1:0] current_value,
    output logic                       last
);
    import csw_pkg::*;

    localparam int CW = $clog2(THREAD_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SREL = 3'b010,
        S_TREL = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic [CW-1:0] pc_reg, pc_next, tc_reg, tc_next;
    logic [CNT_W-1:0] num_reg, num_next, cnt_reg, cnt_next;

    logic out_valid_reg;
    logic [2:0] kind_reg, kind_next;
    logic [THR_W-1:0] thr_reg, thr_next;
    logic to_reg, to_next;
    logic [CNT_W-1:0] rv_reg, rv_next;
    logic signed [VAL_W-1:0] cv_reg;
    logic last_reg, last_next;

    logic emit, can_load, acc;
    csw_ctl_t pctl, tctl;
    logic p_any, t_any;
    logic [THR_W-1:0] p_thr, t_thr;
    logic [CNT_W-1:0] num_eff;

    csw_chain #(.THREAD_SLOTS(THREAD_SLOTS)) u_plain (
        .clk (clk), .rst_n (rst_n), .ctl (pctl), .any_sel (p_any), .sel_thread (p_thr)
    );
    csw_chain #(.THREAD_SLOTS(THREAD_SLOTS)) u_timed (
        .clk (clk), .rst_n (rst_n), .ctl (tctl), .any_sel (t_any), .sel_thread (t_thr)
    );

    assign can_load = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && can_load);
    assign acc      = in_valid && !in_stall;
    assign num_eff  = (release_count == '0) ? CNT_W'(1) : release_count;

    always_comb
    begin
        state_next = state_reg;
        value_next = value_reg;
        pc_next    = pc_reg;
        tc_next    = tc_reg;
        num_next   = num_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        kind_next  = K_REJ;
        thr_next   = '0;
        to_next    = 1'b0;
        rv_next    = '0;
        last_next  = 1'b1;
        pctl       = '0;
        tctl       = '0;
        tctl.rem   = timeout;
        tctl.thread = thread_id;
        pctl.thread = thread_id;
        if (cfg_we)
        begin
            pctl.clear = 1'b1;
            tctl.clear = 1'b1;
            pc_next    = '0;
            tc_next    = '0;
            value_next = cfg_data[VAL_W-1] ? '0 : cfg_data;
            state_next = S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        emit = 1'b1;
                        case (action)
                            ACT_WAIT:
                            begin
                                if (value_reg > 0)
                                begin
                                    value_next = value_reg - VAL_W'(1);
                                    kind_next  = K_ACQ;
                                end
                                else if (({1'b0, pc_reg} + {1'b0, tc_reg})
                                         >= (CW+1)'(THREAD_SLOTS))
                                begin
                                    kind_next = K_REJ;
                                end
                                else
                                begin
                                    value_next = sat_add(value_reg, -(CNT_W+1)'(1));
                                    kind_next  = K_BLOCK;
                                    if (timeout != '0)
                                    begin
                                        tctl.push = 1'b1;
                                        tc_next   = tc_reg + CW'(1);
                                    end
                                    else
                                    begin
                                        pctl.push = 1'b1;
                                        pc_next   = pc_reg + CW'(1);
                                    end
                                end
                            end
                            ACT_SIGNAL:
                            begin
                                if (release_count[CNT_W-1])
                                begin
                                    kind_next = K_REJ;
                                    rv_next   = release_count;
                                end
                                else
                                begin
                                    value_next = sat_add(value_reg, {1'b0, num_eff});
                                    if (value_reg[VAL_W-1])
                                    begin
                                        emit       = 1'b0;
                                        num_next   = num_eff;
                                        cnt_next   = '0;
                                        state_next = S_SREL;
                                    end
                                    else
                                    begin
                                        kind_next = K_SIG;
                                    end
                                end
                            end
                            ACT_TICK:
                            begin
                                emit       = 1'b0;
                                tctl.dec   = 1'b1;
                                state_next = S_TREL;
                            end
                            default:
                            begin
                                kind_next = K_REJ;
                            end
                        endcase
                    end
                end
                S_SREL:
                begin
                    if (can_load)
                    begin
                        emit = 1'b1;
                        if (cnt_reg < num_reg && p_any)
                        begin
                            pctl.rm   = 1'b1;
                            pc_next   = pc_reg - CW'(1);
                            cnt_next  = cnt_reg + CNT_W'(1);
                            kind_next = K_REL;
                            thr_next  = p_thr;
                            last_next = 1'b0;
                        end
                        else if (cnt_reg < num_reg && t_any)
                        begin
                            tctl.rm   = 1'b1;
                            tc_next   = tc_reg - CW'(1);
                            cnt_next  = cnt_reg + CNT_W'(1);
                            kind_next = K_REL;
                            thr_next  = t_thr;
                            last_next = 1'b0;
                        end
                        else
                        begin
                            kind_next  = K_SIG;
                            rv_next    = cnt_reg;
                            state_next = S_IDLE;
                        end
                    end
                end
                S_TREL:
                begin
                    if (can_load)
                    begin
                        emit             = 1'b1;
                        tctl.rm_exp_only = 1'b1;
                        if (t_any)
                        begin
                            // The first expired waiter leaves and gives its place back.
                            tctl.rm    = 1'b1;
                            tc_next    = tc_reg - CW'(1);
                            value_next = sat_add(value_reg, (CNT_W+1)'(1));
                            kind_next  = K_REL;
                            thr_next   = t_thr;
                            to_next    = 1'b1;
                            last_next  = 1'b0;
                        end
                        else
                        begin
                            kind_next  = K_TICK;
                            state_next = S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            value_reg     <= '0;
            pc_reg        <= '0;
            tc_reg        <= '0;
            num_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            value_reg <= value_next;
            pc_reg    <= pc_next;
            tc_reg    <= tc_next;
            num_reg   <= num_next;
            cnt_reg   <= cnt_next;
            if (can_load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && emit)
        begin
            kind_reg <= kind_next;
            thr_reg  <= thr_next;
            to_reg   <= to_next;
            rv_reg   <= rv_next;
            cv_reg   <= value_next;
            last_reg <= last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign released_thread = thr_reg;
    assign timed_out       = to_reg;
    assign return_value    = rv_reg;
    assign current_value   = cv_reg;
    assign last            = last_reg;

endmodule
`default_nettype wire

// ===== rtl/csw_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Waiter cell
// Holds one waiter and takes its right neighbour's contents on removal.
// ---------------------------------------------------------------------------
module csw_cell (
    input  wire                     clk,
    input  wire                     rst_n,
    input  csw_pkg::csw_ctl_t       ctl,
    input  wire                     sel_in,
    input  wire                     free_in,
    input  wire [csw_pkg::THR_W-1:0] sel_thr_in,
    input  csw_pkg::csw_cell_t      nb,
    output csw_pkg::csw_cell_t      cur,
    output logic                    sel_out,
    output logic                    free_out,
    output logic [csw_pkg::THR_W-1:0] sel_thr_out
);
    import csw_pkg::*;

    logic       valid_reg, valid_next;
    logic       exp_reg, exp_next;
    logic [THR_W-1:0] thread_reg, thread_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic       my_sel;

    assign my_sel      = valid_reg && (!ctl.rm_exp_only || exp_reg);
    assign sel_out     = sel_in || my_sel;
    assign free_out    = free_in || !valid_reg;
    assign sel_thr_out = sel_in ? sel_thr_in : thread_reg;

    assign cur.valid  = valid_reg;
    assign cur.exp    = exp_reg;
    assign cur.thread = thread_reg;
    assign cur.rem    = rem_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        exp_next    = exp_reg;
        thread_next = thread_reg;
        rem_next    = rem_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.rm && sel_out)
        begin
            // Every cell from the removed one onwards shifts one place left.
            valid_next  = nb.valid;
            exp_next    = nb.exp;
            thread_next = nb.thread;
            rem_next    = nb.rem;
        end
        else if (ctl.push && !free_in && !valid_reg)
        begin
            valid_next  = 1'b1;
            exp_next    = 1'b0;
            thread_next = ctl.thread;
            rem_next    = ctl.rem;
        end
        else if (ctl.dec && valid_reg)
        begin
            if (rem_reg <= REM_W'(1))
            begin
                exp_next = 1'b1;
            end
            else
            begin
                exp_next = 1'b0;
                rem_next = rem_reg - REM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        thread_reg <= thread_next;
        rem_reg    <= rem_next;
    end

endmodule
`default_nettype wire

// ===== rtl/csw_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Waiter chain
// A row of waiter cells kept packed towards the head in arrival order.
// ---------------------------------------------------------------------------
module csw_chain #(
    parameter int THREAD_SLOTS = csw_pkg::DEF_THREAD_SLOTS
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  csw_pkg::csw_ctl_t         ctl,
    output logic                      any_sel,
    output logic [csw_pkg::THR_W-1:0] sel_thread
);
    import csw_pkg::*;

    logic             sel_c  [THREAD_SLOTS+1];
    logic             free_c [THREAD_SLOTS+1];
    logic [THR_W-1:0] thr_c  [THREAD_SLOTS+1];
    csw_cell_t        data   [THREAD_SLOTS+1];

    assign sel_c[0]     = 1'b0;
    assign free_c[0]    = 1'b0;
    assign thr_c[0]     = '0;
    assign data[THREAD_SLOTS] = '0;

    genvar i;
    generate
        for (i = 0; i < THREAD_SLOTS; i++)
        begin : g_cell
            csw_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .sel_in      (sel_c[i]),
                .free_in     (free_c[i]),
                .sel_thr_in  (thr_c[i]),
                .nb          (data[i+1]),
                .cur         (data[i]),
                .sel_out     (sel_c[i+1]),
                .free_out    (free_c[i+1]),
                .sel_thr_out (thr_c[i+1])
            );
        end
    endgenerate

    assign any_sel    = sel_c[THREAD_SLOTS];
    assign sel_thread = thr_c[THREAD_SLOTS];

endmodule
`default_nettype wire

// ===== bench/counting_semaphore_timed_waits_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Counting semaphore with timed waits: self-checking testbench
// Drives waits, signals, ticks and illegal actions under random idling on
// both channels, predicts every result with a scoreboard model of the semaphore
// and its two waiter stores, and compares each result field by field in order.
// ---------------------------------------------------------------------------
module counting_semaphore_timed_waits_tb;

    import csw_pkg::*;

    localparam logic [1:0] ACT_ILLEGAL = 2'd3;
    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [THR_W-1:0] thread;
        int               remaining;
    } timed_waiter_t;

    typedef struct {
        logic [2:0]              kind;
        logic [THR_W-1:0]        thread;
        logic                    timed_out;
        logic signed [CNT_W-1:0] ret;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } sem_result_t;

    class sem_scoreboard;
        int               value;
        logic [THR_W-1:0] plain_q[$];
        timed_waiter_t    timed_q[$];
        sem_result_t      expected_q[$];
        int               failures;

        function int sat16(int v);
            if (v > 32767)
            begin
                return 32767;
            end
            if (v < -32768)
            begin
                return -32768;
            end
            return v;
        endfunction

        function void configure(logic signed [VAL_W-1:0] init);
            value = (init < 0) ? 0 : int'(init);
            plain_q.delete();
            timed_q.delete();
        endfunction

        function void add_result(logic [2:0] k, logic [THR_W-1:0] thr, logic to, int rv);
            sem_result_t r;
            r.kind = k;
            r.thread = thr;
            r.timed_out = to;
            r.ret = rv[CNT_W-1:0];
            r.value = value[VAL_W-1:0];
            r.last = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void note_input(logic [1:0] act, logic [THR_W-1:0] thr,
                                 logic [REM_W-1:0] tmo, logic signed [CNT_W-1:0] rc);
            int            nv;
            int            num;
            int            released;
            int            i;
            int            rem;
            bit            was_negative;
            timed_waiter_t w;
            case (act)
                ACT_WAIT:
                begin
                    nv = sat16(value - 1);
                    if (nv >= 0)
                    begin
                        value = nv;
                        add_result(K_ACQ, '0, 1'b0, 0);
                    end
                    else if (plain_q.size() + timed_q.size() >= SLOTS)
                    begin
                        add_result(K_REJ, '0, 1'b0, 0);
                    end
                    else
                    begin
                        value = nv;
                        if (tmo != 0)
                        begin
                            w.thread = thr;
                            w.remaining = tmo;
                            timed_q.push_back(w);
                        end
                        else
                        begin
                            plain_q.push_back(thr);
                        end
                        add_result(K_BLOCK, '0, 1'b0, 0);
                    end
                end
                ACT_SIGNAL:
                begin
                    if (rc < 0)
                    begin
                        add_result(K_REJ, '0, 1'b0, rc);
                    end
                    else
                    begin
                        num = (rc == 0) ? 1 : int'(rc);
                        released = 0;
                        was_negative = value < 0;
                        value = sat16(value + num);
                        if (was_negative)
                        begin
                            // Untimed waiters go first, then the timed list in order.
                            while (released < num && plain_q.size() > 0)
                            begin
                                add_result(K_REL, plain_q.pop_front(), 1'b0, 0);
                                released++;
                            end
                            while (released < num && timed_q.size() > 0)
                            begin
                                add_result(K_REL, timed_q[0].thread, 1'b0, 0);
                                timed_q.delete(0);
                                released++;
                            end
                        end
                        add_result(K_SIG, '0, 1'b0, released);
                    end
                end
                ACT_TICK:
                begin
                    i = 0;
                    while (i < timed_q.size())
                    begin
                        rem = timed_q[i].remaining;
                        rem = (rem == 0) ? 0 : rem - 1;
                        if (rem > 0)
                        begin
                            timed_q[i].remaining = rem;
                            i++;
                        end
                        else
                        begin
                            w = timed_q[i];
                            timed_q.delete(i);
                            value = sat16(value + 1);
                            add_result(K_REL, w.thread, 1'b1, 0);
                        end
                    end
                    add_result(K_TICK, '0, 1'b0, 0);
                end
                default:
                begin
                    add_result(K_REJ, '0, 1'b0, 0);
                end
            endcase
            expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void check_result(sem_result_t got);
            sem_result_t want;
            if (expected_q.size() == 0)
            begin
                if (failures < 10)
                begin
                    $display("unexpected result: kind %0d value %0d", got.kind, got.value);
                end
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.thread !== want.thread
                || got.timed_out !== want.timed_out || got.ret !== want.ret
                || got.value !== want.value || got.last !== want.last)
            begin
                if (failures < 10)
                begin
                    $display("mismatch: expected kind %0d thr %0d to %0d ret %0d val %0d last %0d",
                             want.kind, want.thread, want.timed_out, want.ret, want.value,
                             want.last);
                    $display("          actual   kind %0d thr %0d to %0d ret %0d val %0d last %0d",
                             got.kind, got.thread, got.timed_out, got.ret, got.value, got.last);
                end
                failures++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic signed [VAL_W-1:0] cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              action;
    logic [THR_W-1:0]        thread_id;
    logic [REM_W-1:0]        timeout;
    logic signed [CNT_W-1:0] release_count;
    logic                    out_valid;
    logic                    out_stall;
    logic [2:0]              kind;
    logic [THR_W-1:0]        released_thread;
    logic                    timed_out;
    logic signed [CNT_W-1:0] return_value;
    logic signed [VAL_W-1:0] current_value;
    logic                    last;

    sem_scoreboard sb;
    bit            quiet_end;
    int            hold_request;
    int            hold_left;
    int            burst_left;
    int            idle_cycles;

    counting_semaphore_timed_waits dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .thread_id       (thread_id),
        .timeout         (timeout),
        .release_count   (release_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .released_thread (released_thread),
        .timed_out       (timed_out),
        .return_value    (return_value),
        .current_value   (current_value),
        .last            (last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result side: check accepted results and choose the next stall value.
    always @(posedge clk)
    begin
        sem_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind = kind;
            got.thread = released_thread;
            got.timed_out = timed_out;
            got.ret = return_value;
            got.value = current_value;
            got.last = last;
            sb.check_result(got);
        end
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (quiet_end)
        begin
            out_stall <= 1'b0;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(1, 18) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("counting_semaphore_timed_waits_tb failed");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] act, logic [THR_W-1:0] thr,
                             logic [REM_W-1:0] tmo, logic signed [CNT_W-1:0] rc);
        in_valid <= 1'b1;
        action <= act;
        thread_id <= thr;
        timeout <= tmo;
        release_count <= rc;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_input(act, thr, tmo, rc);
    endtask

    task automatic pause_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_initial(logic signed [VAL_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.configure(v);
        @(posedge clk);
    endtask

    // Mostly small timeouts and counts so that waiters pile up and expire.
    task automatic send_random_item(bit gaps);
        int                      pick;
        logic [1:0]              act;
        logic [REM_W-1:0]        tmo;
        logic signed [CNT_W-1:0] rc;
        pick = $urandom_range(0, 99);
        tmo = 0;
        rc = 0;
        if (pick < 42)
        begin
            act = ACT_WAIT;
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                tmo = 0;
            end
            else if (pick < 9)
            begin
                tmo = REM_W'($urandom_range(1, 6));
            end
            else
            begin
                tmo = REM_W'($urandom_range(0, 65535));
            end
        end
        else if (pick < 67)
        begin
            act = ACT_SIGNAL;
            pick = $urandom_range(0, 19);
            if (pick < 15)
            begin
                rc = CNT_W'($urandom_range(0, 3));
            end
            else
            begin
                rc = CNT_W'($urandom_range(0, 255));
            end
        end
        else if (pick < 96)
        begin
            act = ACT_TICK;
        end
        else
        begin
            act = ACT_ILLEGAL;
        end
        if (gaps && $urandom_range(0, 5) == 0)
        begin
            pause_sender($urandom_range(1, 18));
        end
        send_item(act, THR_W'($urandom_range(0, 15)), tmo, rc);
    endtask

    initial
    begin
        logic signed [VAL_W-1:0] settings[5];
        sb = new();
        sb.configure('0);
        sb.failures = 0;
        quiet_end = 0;
        hold_request = 0;
        hold_left = 0;
        burst_left = 0;
        idle_cycles = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        action <= ACT_WAIT;
        thread_id <= '0;
        timeout <= '0;
        release_count <= '0;
        out_stall <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part from the reset value of zero.
        send_item(ACT_WAIT, 4'd3, 16'd0, 8'sd0);
        send_item(ACT_WAIT, 4'd15, 16'hFFFF, 8'sd0);
        send_item(ACT_WAIT, 4'd0, 16'd1, 8'sd0);
        send_item(ACT_WAIT, 4'd3, 16'd2, 8'sd0);
        send_item(ACT_TICK, 4'd0, 16'd0, 8'sd0);
        send_item(ACT_SIGNAL, 4'd0, 16'd0, 8'sd0);
        send_item(ACT_SIGNAL, 4'd0, 16'd0, -8'sd128);
        send_item(ACT_ILLEGAL, 4'd9, 16'd7, 8'sd5);
        send_item(ACT_SIGNAL, 4'd0, 16'd0, 8'sd2);
        send_item(ACT_SIGNAL, 4'd0, 16'd0, 8'sd127);
        send_item(ACT_SIGNAL, 4'd0, 16'd0, -8'sd1);
        wait_drained();

        // Fill both stores, overflow them, then release everything.
        write_initial(16'sd1);
        for (int i = 0; i < 18; i++)
        begin
            send_item(ACT_WAIT, i[3:0], (i % 2) ? 16'd3 : 16'd0, 8'sd0);
        end
        send_item(ACT_TICK, 4'd0, 16'd0, 8'sd0);
        send_item(ACT_TICK, 4'd0, 16'd0, 8'sd0);
        send_item(ACT_TICK, 4'd0, 16'd0, 8'sd0);
        send_item(ACT_SIGNAL, 4'd0, 16'd0, 8'sd127);
        wait_drained();

        settings[0] = 16'sd2;
        settings[1] = -16'sd32768;
        settings[2] = 16'sd32767;
        settings[3] = -16'sd5;
        settings[4] = VAL_W'($urandom_range(0, 4));
        for (int ph = 0; ph < 5; ph++)
        begin
            write_initial(settings[ph]);
            if (ph == 1)
            begin
                // The receiver holds off while items keep coming.
                hold_request = 400;
            end
            if (ph == 4)
            begin
                quiet_end = 1;
            end
            for (int n = 0; n < 88; n++)
            begin
                if (ph == 3 && n == 44)
                begin
                    wait_drained();
                end
                send_random_item(ph != 1 && ph != 4);
            end
            wait_drained();
        end

        if (sb.expected_q.size() != 0)
        begin
            sb.failures++;
        end
        if (sb.failures == 0)
        begin
            $display("counting_semaphore_timed_waits_tb passed");
        end
        else
        begin
            $display("counting_semaphore_timed_waits_tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/csw_pkg.sv
rtl/csw_cell.sv
rtl/csw_chain.sv
rtl/counting_semaphore_timed_waits.sv
bench/counting_semaphore_timed_waits_tb.sv
